>>> rtl/core/sitda_pkg.sv
// shared types and constants for the signed integer to decimal ascii converter
`default_nettype none
package sitda_pkg;

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;
  localparam logic [3:0] DIGIT_ZERO  = 4'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> rtl/core/sitda_front.sv
// front end: takes a transaction and splits it into sign and magnitude
`default_nettype none
module sitda_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  input  wire sitda_pkg::q_status_t  q_status,
  output logic                       busy,
  output logic                       push,
  output logic [DATA_WIDTH:0]        push_data
);

  logic                  negative;
  logic [DATA_WIDTH-1:0] mag;

  assign negative  = in_value[DATA_WIDTH-1];
  // -2^(w-1) negates to itself, which read unsigned is the right magnitude
  assign mag       = negative ? (~in_value + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : in_value;
  assign busy      = q_status.full;
  assign push      = start && !q_status.full;
  assign push_data = {negative, mag};

endmodule
`default_nettype wire

>>> rtl/core/sitda_queue.sv
// two-entry queue between front end and back end
`default_nettype none
module sitda_queue #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output sitda_pkg::q_status_t  q_status
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_status.full  = (count_r == 2'd2);
  assign q_status.empty = (count_r == 2'd0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_data       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sitda_back.sv
// back end: shift-and-add-3 conversion and character output
`default_nettype none
module sitda_back #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sitda_pkg::q_status_t q_status,
  input  wire logic [DATA_WIDTH:0]  pop_data,
  output logic                      pop,
  output logic                      out_valid,
  output logic [5:0]                out_character,
  output logic                      out_last
);

  localparam int NDIG = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(DATA_WIDTH + 1);
  localparam int DW   = $clog2(NDIG + 1);

  sitda_pkg::state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] bin_r, bin_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt;
  logic [BW-1:0]         bcd_adj;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DW-1:0]         dcnt_r, dcnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  started_r, started_nxt;
  logic                  valid_r, valid_nxt;
  logic [5:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic [3:0]            top_digit;

  assign top_digit     = bcd_r[BW-1 -: 4];
  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= sitda_pkg::BCD_ADJ_MIN) ?
                          (bcd_r[4*i +: 4] + sitda_pkg::BCD_ADJ) : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    dcnt_nxt    = dcnt_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    valid_nxt   = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    pop         = 1'b0;
    unique case (state_r)
      sitda_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop         = 1'b1;
          neg_nxt     = pop_data[DATA_WIDTH];
          bin_nxt     = pop_data[DATA_WIDTH-1:0];
          bcd_nxt     = '0;
          cnt_nxt     = CW'(DATA_WIDTH);
          dcnt_nxt    = DW'(NDIG);
          started_nxt = 1'b0;
          state_nxt   = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BW-2:0], bin_r, 1'b0};
        cnt_nxt            = cnt_r - {{(CW-1){1'b0}}, 1'b1};
        if (cnt_r == {{(CW-1){1'b0}}, 1'b1}) begin
          state_nxt = neg_r ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        valid_nxt = 1'b1;
        char_nxt  = sitda_pkg::CHAR_MINUS;
        state_nxt = sitda_pkg::ST_EMIT;
      end
      sitda_pkg::ST_EMIT: begin
        bcd_nxt  = {bcd_r[BW-5:0], sitda_pkg::DIGIT_ZERO};
        dcnt_nxt = dcnt_r - {{(DW-1){1'b0}}, 1'b1};
        // leading zeros are dropped, but the final digit always goes out
        if (started_r || (top_digit != sitda_pkg::DIGIT_ZERO) ||
            (dcnt_r == {{(DW-1){1'b0}}, 1'b1})) begin
          started_nxt = 1'b1;
          valid_nxt   = 1'b1;
          char_nxt    = sitda_pkg::CHAR_ZERO + {2'b00, top_digit};
          last_nxt    = (dcnt_r == {{(DW-1){1'b0}}, 1'b1});
        end
        if (dcnt_r == {{(DW-1){1'b0}}, 1'b1}) begin
          state_nxt = sitda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sitda_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sitda_pkg::ST_IDLE;
      valid_r   <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    dcnt_r <= dcnt_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/signed_int_to_decimal_ascii.sv
// top level of the signed integer to decimal ascii converter
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+----------------------------
//   input   | start, busy, in_value                    | taken when start && !busy
//   result  | out_valid, out_character, out_last       | one-cycle strobe, no stall
//
// the back end takes a transaction from the queue, runs the shift-and-add-3 loop over
// all DATA_WIDTH bits, emits a minus sign when negative, and then walks all NDIG
// digit positions, of which leading zeros give no output; it takes no new transaction
// from the queue until it is back in idle
// the two-entry queue lets the front end take two transactions ahead of the back end
// synchronous active-low reset empties the queue and idles the back end
`default_nettype none
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  output logic                       out_valid,
  output logic [5:0]                 out_character,
  output logic                       out_last
);

  sitda_pkg::q_status_t q_status;
  logic                 push;
  logic                 pop;
  logic [DATA_WIDTH:0]  push_data;
  logic [DATA_WIDTH:0]  pop_data;

  sitda_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .start     (start),
    .in_value  (in_value),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  sitda_queue #(.WIDTH(DATA_WIDTH + 1)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  sitda_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

>>> rtl/core/sitda_checker.sv
// port-level checks for the converter, bound to the top level
`default_nettype none
module sitda_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic [5:0] out_character,
  input wire logic       out_last
);

  logic is_minus;
  logic is_digit;

  assign is_minus = (out_character == sitda_pkg::CHAR_MINUS);
  assign is_digit = (out_character >= sitda_pkg::CHAR_ZERO) &&
                    (out_character <= (sitda_pkg::CHAR_ZERO + 6'd9));

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_minus || is_digit))
    else $error("result character is neither minus nor digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && is_minus) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_digits_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && is_digit && !out_last) |=> (out_valid && is_digit))
    else $error("digit run broken or minus inside a run");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_character (out_character),
  .out_last      (out_last)
);
`default_nettype wire

>>> bench/tb_top.sv
// self-checking testbench for the signed integer to decimal ascii converter
`default_nettype none
module tb_top;

  localparam int VALUE_W = 32;
  localparam int NUM_RANDOM = 350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               drain_first;
  } conv_req_t;

  typedef struct {
    logic [5:0] character;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic [5:0]         out_character;
  logic               out_last;

  conv_req_t  pending_values[$];
  text_char_t expected_text[$];
  logic       item_taken = 1'b0;
  int         total_items = 0;
  int         accepted_items = 0;
  int         error_count = 0;
  int         idle_pct;

  signed_int_to_decimal_ascii #(.DATA_WIDTH(VALUE_W)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decimal text of one value: optional minus, then digits msd first
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W:0] magnitude;
    logic [3:0]       digits[$];
    text_char_t       c;
    magnitude = {1'b0, v};
    if (v[VALUE_W-1]) begin
      magnitude = -{1'b1, v};
      c.character = sitda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    do begin
      digits.push_front(4'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    for (int i = 0; i < digits.size(); i++) begin
      c.character = sitda_pkg::CHAR_ZERO + 6'(digits[i]);
      c.last = (i == digits.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    longint unsigned span;
    logic [VALUE_W-1:0] v;
    int ndig;
    span = 1;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(99);
      default: begin
        ndig = $urandom_range(1, 10);
        repeat (ndig) span = span * 10;
        if (ndig == 10) v = $urandom_range(32'h7fffffff);
        else if ($urandom_range(3) == 0) v = VALUE_W'(span - 1 + $urandom_range(2));
        else v = VALUE_W'($urandom_range(32'(span - 1)));
      end
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic queue_value(input logic [VALUE_W-1:0] v, input logic drain);
    conv_req_t r;
    r.value = v;
    r.drain_first = drain;
    pending_values.push_back(r);
    total_items++;
  endtask

  always @(posedge clk) begin
    if (out_valid && rst_n) begin
      if (expected_text.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected character %0d last %0b", out_character, out_last);
      end else begin
        if (out_character !== expected_text[0].character ||
            out_last !== expected_text[0].last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                     expected_text[0].character, expected_text[0].last,
                     out_character, out_last);
        end
        void'(expected_text.pop_front());
      end
    end
    item_taken = rst_n && start && !busy;
    if (item_taken) begin
      predict_text(in_value);
      accepted_items++;
    end
  end

  // sender idles rarely, then often, then never
  always @(negedge clk) begin
    if (accepted_items < total_items / 3) idle_pct = 12;
    else if (accepted_items < 2 * total_items / 3) idle_pct = 82;
    else idle_pct = 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
    end else if (pending_values.size() != 0 &&
                 !(pending_values[0].drain_first && expected_text.size() != 0) &&
                 $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      in_value <= pending_values[0].value;
      void'(pending_values.pop_front());
    end else begin
      start <= 1'b0;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    queue_value(32'd0, 1'b0);
    queue_value(32'd1, 1'b0);
    queue_value(-32'sd1, 1'b0);
    queue_value(32'd9, 1'b0);
    queue_value(32'd10, 1'b0);
    queue_value(-32'sd10, 1'b0);
    queue_value(32'h7fffffff, 1'b0);
    queue_value(32'h80000000, 1'b0);
    queue_value(32'h80000001, 1'b0);
    queue_value(32'h7ffffffe, 1'b0);
    queue_value(32'd99, 1'b0);
    queue_value(32'd100, 1'b0);
    queue_value(-32'sd99, 1'b0);
    queue_value(32'd999999999, 1'b0);
    queue_value(32'd1000000000, 1'b0);
    queue_value(-32'sd1000000000, 1'b0);
    queue_value(32'h55555555, 1'b0);
    queue_value(32'haaaaaaaa, 1'b0);
    queue_value(32'd12345, 1'b0);
    queue_value(-32'sd7, 1'b0);
    queue_value(32'hffffff00, 1'b0);
    for (int i = 0; i < NUM_RANDOM; i++)
      queue_value(random_value(), (i % 60) == 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_items < total_items) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/sitda_pkg.sv
rtl/core/sitda_front.sv
rtl/core/sitda_queue.sv
rtl/core/sitda_back.sv
rtl/core/signed_int_to_decimal_ascii.sv
rtl/core/sitda_checker.sv
bench/tb_top.sv
